/* hdl/tle_pkg.sv */
// Shared constants, codes and control/status types of the terminal line editor.
`timescale 1ns / 1ps
`default_nettype none

package tle_pkg;

    localparam int PROMPT_LEN = 2;

    localparam logic [7:0] CHR_PROMPT0  = 8'h3e;
    localparam logic [7:0] CHR_PROMPT1  = 8'h20;
    localparam logic [7:0] CHR_LF       = 8'h0a;
    localparam logic [7:0] CHR_CR       = 8'h0d;
    localparam logic [7:0] CHR_BS       = 8'h08;
    localparam logic [7:0] CHR_SPACE    = 8'h20;
    localparam logic [7:0] CHR_LBRACKET = 8'h5b;
    localparam logic [7:0] CHR_K        = 8'h4b;
    localparam logic [7:0] CHR_C        = 8'h43;
    localparam logic [7:0] CHR_D        = 8'h44;
    localparam logic [7:0] PRINT_LO     = 8'h20;
    localparam logic [7:0] PRINT_HI     = 8'h7e;

    localparam logic [7:0] KEY_ESC    = 8'h1b;
    localparam logic [7:0] KEY_DEL    = 8'h7f;
    localparam logic [7:0] KEY_CTRL_A = 8'h01;
    localparam logic [7:0] KEY_CTRL_B = 8'h02;
    localparam logic [7:0] KEY_CTRL_C = 8'h03;
    localparam logic [7:0] KEY_CTRL_E = 8'h05;
    localparam logic [7:0] KEY_CTRL_F = 8'h06;
    localparam logic [7:0] KEY_CTRL_H = 8'h08;
    localparam logic [7:0] KEY_CTRL_L = 8'h0c;
    localparam logic [7:0] KEY_CTRL_M = 8'h0d;

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_ESC   = 2'd1;
    localparam logic [1:0] MODE_CSI   = 2'd2;

    typedef enum logic [1:0] {
        SRC_CONST,
        SRC_STORE,
        SRC_RX
    } t_out_src;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_PROMPT,
        IDX_LEN,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef struct packed {
        logic       ld_rx;
        logic       ins;
        logic       del;
        logic       cur_inc;
        logic       cur_dec;
        logic       cur_home;
        logic       cur_end;
        logic       line_rst;
        t_idx_op    idx_op;
        logic       emit;
        t_out_src   src;
        logic [7:0] cbyte;
        logic       kind;
        logic       last;
    } t_tle_cmd;

    typedef struct packed {
        logic at_prompt;
        logic at_end;
        logic full;
        logic empty;
        logic idx_tail;
        logic idx_cur_next;
        logic out_free;
    } t_tle_sts;

endpackage

`default_nettype wire

/* hdl/tle_stream_if.sv */
// Valid/ready channel interfaces for received bytes and emitted beats.
`timescale 1ns / 1ps
`default_nettype none

interface tle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface tle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_kind;
    logic       out_last;

    modport source (output valid, output out_byte, output out_kind, output out_last,
                    input ready);
    modport sink (input valid, input out_byte, input out_kind, input out_last,
                  output ready);
endinterface

`default_nettype wire

/* hdl/tle_datapath.sv */
// Line store, length, cursor, read index and output beat register.
`timescale 1ns / 1ps
`default_nettype none

module tle_datapath
    import tle_pkg::*;
#(
    parameter int LINE_BYTES = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_rx_byte,
    input  wire t_tle_cmd   i_cmd,
    output t_tle_sts        o_sts,
    tle_out_if.source       o_tx
);

    localparam int IW = $clog2(LINE_BYTES);

    logic [7:0]    r_store [LINE_BYTES];
    logic [7:0]    n_store [LINE_BYTES];
    logic [IW-1:0] r_len, n_len;
    logic [IW-1:0] r_cur, n_cur;
    logic [IW-1:0] r_idx, n_idx;
    logic [7:0]    r_rx;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_byte, n_out_byte;
    logic          r_out_kind, n_out_kind;
    logic          r_out_last, n_out_last;
    logic [IW-1:0] w_prompt;
    logic [IW-1:0] w_del_pos;
    logic          w_out_free;

    assign w_prompt   = IW'(PROMPT_LEN);
    assign w_del_pos  = r_cur - 1'b1;
    assign w_out_free = !r_out_valid || o_tx.ready;

    always_comb begin
        n_store = r_store;
        if (i_cmd.line_rst) begin
            for (int i = 0; i < LINE_BYTES; i++) begin
                n_store[i] = 8'h00;
            end
            n_store[0] = CHR_PROMPT0;
            n_store[1] = CHR_PROMPT1;
        end else if (i_cmd.ins) begin
            for (int i = 1; i < LINE_BYTES; i++) begin
                if (IW'(i) > r_cur && IW'(i) <= r_len) begin
                    n_store[i] = r_store[i-1];
                end
            end
            n_store[r_cur] = i_rx_byte;
        end else if (i_cmd.del) begin
            for (int i = 0; i < LINE_BYTES - 1; i++) begin
                if (IW'(i) >= w_del_pos && IW'(i + 1) < r_len) begin
                    n_store[i] = r_store[i+1];
                end
            end
            n_store[r_len - 1'b1] = 8'h00;
        end
    end

    always_comb begin
        n_len = r_len;
        priority if (i_cmd.line_rst) begin
            n_len = w_prompt;
        end else if (i_cmd.ins) begin
            n_len = r_len + 1'b1;
        end else if (i_cmd.del) begin
            n_len = r_len - 1'b1;
        end else begin
            n_len = r_len;
        end

        n_cur = r_cur;
        priority if (i_cmd.line_rst || i_cmd.cur_home) begin
            n_cur = w_prompt;
        end else if (i_cmd.cur_inc) begin
            n_cur = r_cur + 1'b1;
        end else if (i_cmd.cur_dec) begin
            n_cur = r_cur - 1'b1;
        end else if (i_cmd.cur_end) begin
            n_cur = r_len;
        end else begin
            n_cur = r_cur;
        end

        unique case (i_cmd.idx_op)
            IDX_HOLD:   n_idx = r_idx;
            IDX_ZERO:   n_idx = '0;
            IDX_PROMPT: n_idx = w_prompt;
            IDX_LEN:    n_idx = r_len;
            IDX_INC:    n_idx = r_idx + 1'b1;
            IDX_DEC:    n_idx = r_idx - 1'b1;
            default:    n_idx = r_idx;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_kind  = r_out_kind;
        n_out_last  = r_out_last;
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_out_kind  = i_cmd.kind;
            n_out_last  = i_cmd.last;
            unique case (i_cmd.src)
                SRC_CONST: n_out_byte = i_cmd.cbyte;
                SRC_STORE: n_out_byte = r_store[r_idx];
                SRC_RX:    n_out_byte = r_rx;
                default:   n_out_byte = i_cmd.cbyte;
            endcase
        end else if (o_tx.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LINE_BYTES; i++) begin
                r_store[i] <= (i == 0) ? CHR_PROMPT0 : (i == 1) ? CHR_PROMPT1 : 8'h00;
            end
            r_len       <= w_prompt;
            r_cur       <= w_prompt;
            r_out_valid <= 1'b0;
        end else begin
            r_store     <= n_store;
            r_len       <= n_len;
            r_cur       <= n_cur;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_out_byte <= n_out_byte;
        r_out_kind <= n_out_kind;
        r_out_last <= n_out_last;
        if (i_cmd.ld_rx) begin
            r_rx <= i_rx_byte;
        end
    end

    assign o_sts.at_prompt    = (r_cur == w_prompt);
    assign o_sts.at_end       = (r_cur == r_len);
    assign o_sts.full         = (r_len >= IW'(LINE_BYTES - 1));
    assign o_sts.empty        = (r_len == w_prompt);
    assign o_sts.idx_tail     = (r_idx == r_len - 1'b1);
    assign o_sts.idx_cur_next = (r_idx == r_cur + 1'b1);
    assign o_sts.out_free     = w_out_free;

    assign o_tx.valid    = r_out_valid;
    assign o_tx.out_byte = r_out_byte;
    assign o_tx.out_kind = r_out_kind;
    assign o_tx.out_last = r_out_last;

endmodule

`default_nettype wire

/* hdl/tle_ctrl.sv */
// Key decoder, escape parser and output sequencer state machine.
`timescale 1ns / 1ps
`default_nettype none

module tle_ctrl
    import tle_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [7:0] i_rx_byte,
    input  wire t_tle_sts   i_sts,
    output logic            o_in_ready,
    output t_tle_cmd        o_cmd
);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_ECHO    = 8'b0000_0010,
        ST_BSB     = 8'b0000_0100,
        ST_ESCSEQ  = 8'b0000_1000,
        ST_RD_HEAD = 8'b0001_0000,
        ST_RD_LINE = 8'b0010_0000,
        ST_RD_BACK = 8'b0100_0000,
        ST_COMMIT  = 8'b1000_0000
    } t_state;

    // What runs after the current output run has finished.
    typedef enum logic [2:0] {
        FOL_NONE,
        FOL_INC,
        FOL_DEC,
        FOL_RESET,
        FOL_COMMIT
    } t_follow;

    t_state     r_state, n_state;
    t_follow    r_follow, n_follow;
    logic [1:0] r_mode, n_mode;
    logic [1:0] r_cnt, n_cnt;
    logic       r_echo_rx, n_echo_rx;
    logic       r_esc_right, n_esc_right;
    logic       w_part_end;
    logic       w_printable;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_printable = (i_rx_byte >= PRINT_LO) && (i_rx_byte <= PRINT_HI);

    always_comb begin
        n_state     = r_state;
        n_follow    = r_follow;
        n_mode      = r_mode;
        n_cnt       = r_cnt;
        n_echo_rx   = r_echo_rx;
        n_esc_right = r_esc_right;
        w_part_end  = 1'b0;
        o_cmd        = '0;
        o_cmd.idx_op = IDX_HOLD;
        o_cmd.src    = SRC_CONST;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.ld_rx = 1'b1;
                    n_cnt       = 2'd0;
                    n_follow    = FOL_NONE;
                    unique case (r_mode)
                        MODE_PLAIN: begin
                            priority if (w_printable) begin
                                if (!i_sts.full) begin
                                    o_cmd.ins = 1'b1;
                                    n_follow  = FOL_INC;
                                    n_echo_rx = 1'b1;
                                    n_state   = i_sts.at_end ? ST_ECHO : ST_RD_HEAD;
                                end
                            end else if (i_rx_byte == KEY_CTRL_L) begin
                                n_state = ST_RD_HEAD;
                            end else if (i_rx_byte == KEY_CTRL_C) begin
                                n_echo_rx = 1'b0;
                                n_follow  = FOL_RESET;
                                n_state   = ST_ECHO;
                            end else if (i_rx_byte == KEY_CTRL_B) begin
                                if (!i_sts.at_prompt) begin
                                    o_cmd.cur_dec = 1'b1;
                                    n_esc_right   = 1'b0;
                                    n_state       = ST_ESCSEQ;
                                end
                            end else if (i_rx_byte == KEY_CTRL_F) begin
                                if (!i_sts.at_end) begin
                                    o_cmd.cur_inc = 1'b1;
                                    n_esc_right   = 1'b1;
                                    n_state       = ST_ESCSEQ;
                                end
                            end else if (i_rx_byte == KEY_CTRL_A) begin
                                o_cmd.cur_home = 1'b1;
                                n_state        = ST_RD_HEAD;
                            end else if (i_rx_byte == KEY_CTRL_E) begin
                                o_cmd.cur_end = 1'b1;
                                n_state       = ST_RD_HEAD;
                            end else if (i_rx_byte == KEY_DEL || i_rx_byte == KEY_CTRL_H) begin
                                if (!i_sts.at_prompt) begin
                                    o_cmd.del = 1'b1;
                                    n_follow  = FOL_DEC;
                                    n_state   = i_sts.at_end ? ST_BSB : ST_RD_HEAD;
                                end
                            end else if (i_rx_byte == KEY_CTRL_M) begin
                                n_echo_rx = 1'b0;
                                n_follow  = i_sts.empty ? FOL_RESET : FOL_COMMIT;
                                n_state   = ST_ECHO;
                            end else if (i_rx_byte == KEY_ESC) begin
                                n_mode = MODE_ESC;
                            end else begin
                                n_mode = MODE_PLAIN;
                            end
                        end
                        MODE_ESC: begin
                            n_mode = (i_rx_byte == CHR_LBRACKET) ? MODE_CSI : MODE_PLAIN;
                        end
                        MODE_CSI: begin
                            n_mode = MODE_PLAIN;
                            if (i_rx_byte == CHR_C && !i_sts.at_end) begin
                                o_cmd.cur_inc = 1'b1;
                                n_esc_right   = 1'b1;
                                n_state       = ST_ESCSEQ;
                            end else if (i_rx_byte == CHR_D && !i_sts.at_prompt) begin
                                o_cmd.cur_dec = 1'b1;
                                n_esc_right   = 1'b0;
                                n_state       = ST_ESCSEQ;
                            end
                        end
                        default: begin
                            n_mode = MODE_PLAIN;
                        end
                    endcase
                end
            end
            ST_ECHO: begin
                if (i_sts.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.src   = r_echo_rx ? SRC_RX : SRC_CONST;
                    o_cmd.cbyte = CHR_LF;
                    w_part_end  = 1'b1;
                end
            end
            ST_BSB: begin
                if (i_sts.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.cbyte = (r_cnt == 2'd1) ? CHR_SPACE : CHR_BS;
                    n_cnt       = r_cnt + 2'd1;
                    w_part_end  = (r_cnt == 2'd2);
                end
            end
            ST_ESCSEQ: begin
                if (i_sts.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.cbyte = (r_cnt == 2'd0) ? KEY_ESC :
                                  (r_cnt == 2'd1) ? CHR_LBRACKET :
                                  r_esc_right     ? CHR_C : CHR_D;
                    n_cnt       = r_cnt + 2'd1;
                    w_part_end  = (r_cnt == 2'd2);
                end
            end
            ST_RD_HEAD: begin
                if (i_sts.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.cbyte = (r_cnt == 2'd0) ? CHR_CR :
                                  (r_cnt == 2'd1) ? KEY_ESC :
                                  (r_cnt == 2'd2) ? CHR_LBRACKET : CHR_K;
                    n_cnt       = r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        o_cmd.idx_op = IDX_ZERO;
                        n_state      = ST_RD_LINE;
                    end
                end
            end
            ST_RD_LINE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_STORE;
                    if (!i_sts.idx_tail) begin
                        o_cmd.idx_op = IDX_INC;
                    end else if (!i_sts.at_end) begin
                        o_cmd.idx_op = IDX_LEN;
                        n_state      = ST_RD_BACK;
                    end else begin
                        w_part_end = 1'b1;
                    end
                end
            end
            ST_RD_BACK: begin
                if (i_sts.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.cbyte = CHR_BS;
                    if (i_sts.idx_cur_next) begin
                        w_part_end = 1'b1;
                    end else begin
                        o_cmd.idx_op = IDX_DEC;
                    end
                end
            end
            ST_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_STORE;
                    o_cmd.kind = 1'b1;
                    if (i_sts.idx_tail) begin
                        w_part_end = 1'b1;
                    end else begin
                        o_cmd.idx_op = IDX_INC;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        o_cmd.last = w_part_end && (r_follow == FOL_NONE);

        if (w_part_end) begin
            n_cnt = 2'd0;
            unique case (r_follow)
                FOL_NONE: begin
                    n_state = ST_IDLE;
                end
                FOL_INC: begin
                    o_cmd.cur_inc = 1'b1;
                    n_follow      = FOL_NONE;
                    n_state       = ST_RD_HEAD;
                end
                FOL_DEC: begin
                    o_cmd.cur_dec = 1'b1;
                    n_follow      = FOL_NONE;
                    n_state       = ST_RD_HEAD;
                end
                FOL_RESET: begin
                    o_cmd.line_rst = 1'b1;
                    n_mode         = MODE_PLAIN;
                    n_follow       = FOL_NONE;
                    n_state        = ST_RD_HEAD;
                end
                FOL_COMMIT: begin
                    o_cmd.idx_op = IDX_PROMPT;
                    n_follow     = FOL_RESET;
                    n_state      = ST_COMMIT;
                end
                default: begin
                    n_follow = FOL_NONE;
                    n_state  = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_follow <= FOL_NONE;
            r_mode   <= MODE_PLAIN;
            r_cnt    <= 2'd0;
        end else begin
            r_state  <= n_state;
            r_follow <= n_follow;
            r_mode   <= n_mode;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_echo_rx   <= n_echo_rx;
        r_esc_right <= n_esc_right;
    end

endmodule

`default_nettype wire

/* hdl/terminal_line_editor.sv */
// Top level of the terminal line editor: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// Each received byte is taken while the editor is idle, and its result beats
// then leave through a registered output at one beat per cycle when the sink
// keeps ready high. A byte causes N beats, where N runs from zero up to
// 4 * LINE_BYTES - 1 (so 63 by default, for an insert just after the prompt
// that fills the line, which redraws twice). The sequencer emits every beat
// through the single output register, which sets the beat rate. The line
// holds at most LINE_BYTES - 1 bytes including the "> " prompt; out_kind
// marks the bytes of a committed line, and out_last marks the final beat
// of each input byte.
module terminal_line_editor
    import tle_pkg::*;
#(
    parameter int LINE_BYTES = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tle_in_if.sink    i_rx,
    tle_out_if.source o_tx
);

    t_tle_cmd w_cmd;
    t_tle_sts w_sts;
    logic     w_in_ready;

    assign i_rx.ready = w_in_ready;

    tle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_rx.valid),
        .i_rx_byte  (i_rx.rx_byte),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    tle_datapath #(
        .LINE_BYTES (LINE_BYTES)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx_byte (i_rx.rx_byte),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .o_tx      (o_tx)
    );

endmodule

`default_nettype wire

/* hdl/tle_checker.sv */
// Port-level checker for the terminal line editor and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module tle_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_out_kind,
    input wire logic       i_out_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_out_kind) && $stable(i_out_last))
        else $error("Stalled output beat changed.");

    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |-> !i_in_ready)
        else $error("Input taken while a result run was still in progress.");

    a_cmd_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind |-> (i_out_byte >= 8'h20) && (i_out_byte <= 8'h7e))
        else $error("Committed line beat is not a printable byte.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Output beat valid right after reset.");

endmodule

bind terminal_line_editor tle_checker u_tle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_rx.ready),
    .i_out_valid (o_tx.valid),
    .i_out_ready (o_tx.ready),
    .i_out_byte  (o_tx.out_byte),
    .i_out_kind  (o_tx.out_kind),
    .i_out_last  (o_tx.out_last)
);

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench that predicts the editor's echo and command beats per key.
`timescale 1ns / 1ps

module testbench;
    import tle_pkg::*;

    localparam int LINE_BYTES = 16;
    localparam int KEYS_WANTED = 210;

    typedef struct packed {
        logic [7:0] val;
        logic       kind;
        logic       last;
    } t_beat;

    // Shadow copy of the editor: tracks the line and cursor, and queues the beats due per key.
    class line_editor_shadow;
        logic [1:0] mode;
        logic [7:0] text [LINE_BYTES];
        int         len;
        int         cur;
        t_beat      step_q[$];
        t_beat      beats_due[$];
        int         errors;

        function new();
            errors = 0;
            clear_line();
        endfunction

        function void put(logic [7:0] b, logic k);
            t_beat bt;
            bt.val = b;
            bt.kind = k;
            bt.last = 1'b0;
            step_q.push_back(bt);
        endfunction

        function void redraw();
            put(CHR_CR, 1'b0);
            put(KEY_ESC, 1'b0);
            put(CHR_LBRACKET, 1'b0);
            put(CHR_K, 1'b0);
            for (int i = 0; i < len; i++) put(text[i], 1'b0);
            for (int i = len; i > cur; i--) put(CHR_BS, 1'b0);
        endfunction

        function void clear_line();
            for (int i = 0; i < LINE_BYTES; i++) text[i] = 8'h00;
            text[0] = CHR_PROMPT0;
            text[1] = CHR_PROMPT1;
            mode = MODE_PLAIN;
            len = PROMPT_LEN;
            cur = PROMPT_LEN;
        endfunction

        function void move_right();
            if (cur < len) begin
                cur++;
                put(KEY_ESC, 1'b0);
                put(CHR_LBRACKET, 1'b0);
                put(CHR_C, 1'b0);
            end
        endfunction

        function void move_left();
            if (cur > PROMPT_LEN) begin
                cur--;
                put(KEY_ESC, 1'b0);
                put(CHR_LBRACKET, 1'b0);
                put(CHR_D, 1'b0);
            end
        endfunction

        function void insert_key(logic [7:0] c);
            int p;
            p = cur;
            if (len + 1 >= LINE_BYTES) return;
            for (int i = len; i > p; i--) text[i] = text[i - 1];
            text[p] = c;
            len++;
            if (p + 1 == len) put(c, 1'b0);
            else redraw();
            cur++;
            redraw();
        endfunction

        function void erase_key();
            int p;
            if (cur <= PROMPT_LEN || cur > len) return;
            p = cur - 1;
            for (int i = p; i + 1 < len; i++) text[i] = text[i + 1];
            len--;
            text[len] = 8'h00;
            if (p == len) begin
                put(CHR_BS, 1'b0);
                put(CHR_SPACE, 1'b0);
                put(CHR_BS, 1'b0);
            end else begin
                redraw();
            end
            cur--;
            redraw();
        endfunction

        function void plain_key(logic [7:0] c);
            if (c >= PRINT_LO && c <= PRINT_HI) begin
                insert_key(c);
                return;
            end
            case (c)
                KEY_CTRL_L: redraw();
                KEY_CTRL_C: begin
                    put(CHR_LF, 1'b0);
                    clear_line();
                    redraw();
                end
                KEY_CTRL_B: move_left();
                KEY_CTRL_F: move_right();
                KEY_CTRL_A: begin
                    cur = PROMPT_LEN;
                    redraw();
                end
                KEY_CTRL_E: begin
                    cur = len;
                    redraw();
                end
                KEY_DEL, KEY_CTRL_H: erase_key();
                KEY_CTRL_M: begin
                    put(CHR_LF, 1'b0);
                    for (int i = PROMPT_LEN; i < len; i++) put(text[i], 1'b1);
                    clear_line();
                    redraw();
                end
                KEY_ESC: mode = MODE_ESC;
                default: ;
            endcase
        endfunction

        // Notes an accepted key and queues the beats it causes.
        function void take_key(logic [7:0] c);
            t_beat bt;
            step_q.delete();
            case (mode)
                MODE_PLAIN: plain_key(c);
                MODE_ESC: mode = (c == CHR_LBRACKET) ? MODE_CSI : MODE_PLAIN;
                MODE_CSI: begin
                    if (c == CHR_C) move_right();
                    else if (c == CHR_D) move_left();
                    mode = MODE_PLAIN;
                end
                default: mode = MODE_PLAIN;
            endcase
            for (int i = 0; i < step_q.size(); i++) begin
                bt = step_q[i];
                bt.last = (i == step_q.size() - 1);
                beats_due.push_back(bt);
            end
        endfunction

        function void check_beat(logic [7:0] b, logic k, logic l);
            t_beat bt;
            if (beats_due.size() == 0) begin
                $error("out_byte: no beat expected, got %h", b);
                errors++;
                return;
            end
            bt = beats_due.pop_front();
            if (b !== bt.val) begin
                $error("out_byte: expected %h, got %h", bt.val, b);
                errors++;
            end
            if (k !== bt.kind) begin
                $error("out_kind: expected %b, got %b", bt.kind, k);
                errors++;
            end
            if (l !== bt.last) begin
                $error("out_last: expected %b, got %b", bt.last, l);
                errors++;
            end
        endfunction

        function int pending();
            return beats_due.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    tle_in_if  rx_if ();
    tle_out_if tx_if ();

    line_editor_shadow shadow;
    int burst_left = 0;
    int sent_keys = 0;

    terminal_line_editor #(
        .LINE_BYTES(LINE_BYTES)
    ) uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_rx   (rx_if),
        .o_tx   (tx_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_key(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
                rx_if.valid <= 1'b0;
                rx_if.rx_byte <= 8'($urandom);
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge clk); while (!rx_if.ready);
        shadow.take_key(b);
        sent_keys++;
    endtask

    task automatic send_cursor_key();
        case ($urandom_range(0, 5))
            0: send_key(KEY_CTRL_B);
            1: send_key(KEY_CTRL_F);
            2: send_key(KEY_CTRL_A);
            3: send_key(KEY_CTRL_E);
            4: begin
                send_key(KEY_ESC);
                send_key(CHR_LBRACKET);
                send_key(CHR_C);
            end
            default: begin
                send_key(KEY_ESC);
                send_key(CHR_LBRACKET);
                send_key(CHR_D);
            end
        endcase
    endtask

    // Receiver: ready patterns of its own, with one long hold-off early in the run.
    initial begin
        int seg;
        int n;
        int hi;
        int lo;
        seg = 0;
        forever begin
            seg++;
            if (seg == 3) begin
                tx_if.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end else begin
                n = $urandom_range(20, 200);
                case ($urandom_range(0, 3))
                    0: repeat (n) begin
                        tx_if.ready <= 1'b1;
                        @(posedge clk);
                    end
                    1: repeat (n) begin
                        tx_if.ready <= 1'($urandom_range(0, 1));
                        @(posedge clk);
                    end
                    2: begin
                        hi = $urandom_range(1, 5);
                        lo = $urandom_range(1, 6);
                        repeat (n / (hi + lo) + 1) begin
                            repeat (hi) begin
                                tx_if.ready <= 1'b1;
                                @(posedge clk);
                            end
                            repeat (lo) begin
                                tx_if.ready <= 1'b0;
                                @(posedge clk);
                            end
                        end
                    end
                    default: repeat (n) begin
                        tx_if.ready <= ($urandom_range(0, 9) != 0);
                        @(posedge clk);
                    end
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && tx_if.valid && tx_if.ready) begin
            shadow.check_beat(tx_if.out_byte, tx_if.out_kind, tx_if.out_last);
        end
    end

    initial begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [7:0] opening_keys[$];
        int run;
        shadow = new();
        opening_keys = '{
            KEY_CTRL_H, KEY_CTRL_B, KEY_CTRL_F, KEY_CTRL_M,
            PRINT_LO, PRINT_HI, 8'h71,
            KEY_CTRL_B, KEY_ESC, CHR_LBRACKET, CHR_D,
            8'h7a, KEY_DEL,
            KEY_CTRL_E, KEY_CTRL_H,
            KEY_ESC, CHR_LBRACKET, CHR_C,
            KEY_CTRL_A, KEY_CTRL_F, KEY_CTRL_L,
            KEY_ESC, 8'h78, KEY_ESC, CHR_LBRACKET, 8'h41,
            8'hff, KEY_CTRL_M,
            8'h6b, KEY_CTRL_C
        };
        rst_n <= 1'b0;
        rx_if.valid <= 1'b0;
        rx_if.rx_byte <= 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_keys[i]) send_key(opening_keys[i]);

        while (sent_keys < KEYS_WANTED) begin
            run = $urandom_range(0, 99);
            if (run < 35) begin
                repeat ($urandom_range(1, 14)) send_key(8'($urandom_range(PRINT_LO, PRINT_HI)));
            end else if (run < 50) begin
                send_cursor_key();
            end else if (run < 65) begin
                repeat ($urandom_range(1, 3)) begin
                    send_key(($urandom_range(0, 1) != 0) ? KEY_DEL : KEY_CTRL_H);
                end
            end else if (run < 72) begin
                send_key(KEY_CTRL_L);
            end else if (run < 78) begin
                send_key(KEY_CTRL_M);
            end else if (run < 81) begin
                send_key(KEY_CTRL_C);
            end else if (run < 90) begin
                send_key(8'($urandom));
            end else begin
                send_key(KEY_ESC);
                if ($urandom_range(0, 1) != 0) send_key(CHR_LBRACKET);
                send_key(8'($urandom));
            end
        end
        rx_if.valid <= 1'b0;

        while (shadow.pending() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        if (shadow.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/tle_pkg.sv
hdl/tle_stream_if.sv
hdl/tle_datapath.sv
hdl/tle_ctrl.sv
hdl/terminal_line_editor.sv
hdl/tle_checker.sv
tb/testbench.sv
